@@ rtl/core/mcpft_pkg.sv @@
// Shared types and constants for the pipe table core.
// No dependencies; the controller, datapath and top level refer to it by scoped names.
package mcpft_pkg;

   // default sizing of the table
   localparam int PipeCountDef   = 16;
   localparam int PipeDepthDef   = 4096;
   localparam int EndCountMaxDef = 255;
   localparam int MaxRunDef      = 64;

   // request action codes
   typedef enum logic [2:0] {
      ACT_CREATE  = 3'd0,
      ACT_ABANDON = 3'd1,
      ACT_ADD     = 3'd2,
      ACT_RELEASE = 3'd3,
      ACT_READ    = 3'd4,
      ACT_WRITE   = 3'd5
   } action_type;

   // response status codes
   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_EMPTY     = 4'd1,
      ST_EOF       = 4'd2,
      ST_FULL      = 4'd3,
      ST_NO_READER = 4'd4,
      ST_BAD_SLOT  = 4'd5,
      ST_NO_FREE   = 4'd6,
      ST_UNDERFLOW = 4'd7,
      ST_OVERFLOW  = 4'd8
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch the accepted request
      logic commit;      // update the table and load the response
      logic rd_issue;    // read one byte of a run from the store
      logic rd_capture;  // load the fetched byte into the response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run_start;   // the request is a read that takes at least one byte
      logic run_more;    // bytes of the run are still to be sent
   } stat_type;

endpackage

@@ rtl/core/mcpft_req_if.sv @@
// Request channel of the pipe table core: valid/ready plus request fields.
// Standalone; no package use.
interface mcpft_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] slot;
   logic       write_end;
   logic [7:0] data_byte;
   logic [6:0] read_length;

   modport source (output valid, action, slot, write_end, data_byte, read_length,
                   input ready);
   modport sink   (input valid, action, slot, write_end, data_byte, read_length,
                   output ready);
endinterface

@@ rtl/core/mcpft_rsp_if.sv @@
// Response channel of the pipe table core: valid/ready plus response fields.
// Standalone; no package use.
interface mcpft_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [3:0]  created_slot;
   logic [7:0]  read_data;
   logic        last_result;
   logic [7:0]  readers_now;
   logic [7:0]  writers_now;
   logic [12:0] bytes_held;
   logic [4:0]  pipes_in_use;

   modport source (output valid, status, created_slot, read_data, last_result,
                   readers_now, writers_now, bytes_held, pipes_in_use, input ready);
   modport sink   (input valid, status, created_slot, read_data, last_result,
                   readers_now, writers_now, bytes_held, pipes_in_use, output ready);
endinterface

@@ rtl/core/mcpft_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcpft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/mcpft_ctrl.sv @@
// Controller of the pipe table core: sequences lookup, byte runs and response.
// Uses mcpft_pkg command and status types.
module mcpft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcpft_pkg::cmd_type cmd,
   input  mcpft_pkg::stat_type stat
);
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_LOOKUP  = 5'b00010,
      S_RD_ADDR = 5'b00100,
      S_RD_DATA = 5'b01000,
      S_RESP    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_LOOKUP;
         S_LOOKUP:  state_in = stat.run_start ? S_RD_ADDR : S_RESP;
         S_RD_ADDR: state_in = S_RD_DATA;
         S_RD_DATA: state_in = S_RESP;
         S_RESP: begin
            if (rsp_ready) state_in = stat.run_more ? S_RD_ADDR : S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // handshakes and commands
   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_RESP);
   assign cmd.capture    = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit     = (state_ff == S_LOOKUP);
   assign cmd.rd_issue   = (state_ff == S_RD_ADDR);
   assign cmd.rd_capture = (state_ff == S_RD_DATA);
endmodule

@@ rtl/core/mcpft_dp.sv @@
// Datapath of the pipe table core: per-slot table, byte store, response regs.
// Uses mcpft_pkg and mcpft_ram.
module mcpft_dp #(
   parameter int PIPE_COUNT    = mcpft_pkg::PipeCountDef,
   parameter int PIPE_DEPTH    = mcpft_pkg::PipeDepthDef,
   parameter int END_COUNT_MAX = mcpft_pkg::EndCountMaxDef,
   parameter int MAX_RUN       = mcpft_pkg::MaxRunDef
) (
   input  logic               clock,
   input  logic               reset,
   input  mcpft_pkg::cmd_type  cmd,
   output mcpft_pkg::stat_type stat,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_slot,
   input  logic               req_write_end,
   input  logic [7:0]         req_data_byte,
   input  logic [6:0]         req_read_length,
   output logic [3:0]         rsp_status,
   output logic [3:0]         rsp_created_slot,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_last_result,
   output logic [7:0]         rsp_readers_now,
   output logic [7:0]         rsp_writers_now,
   output logic [12:0]        rsp_bytes_held,
   output logic [4:0]         rsp_pipes_in_use
);
   localparam int SLOT_W = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
   localparam int CNT_W  = $clog2(END_COUNT_MAX + 1);
   localparam int PTR_W  = $clog2(PIPE_DEPTH);
   localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
   localparam int TOT_W  = $clog2(PIPE_COUNT + 1);
   localparam int RUN_W  = $clog2(MAX_RUN + 1);
   localparam int LEN_W  = (FILL_W > 7) ? FILL_W : 7;
   localparam int MEM_DEPTH = PIPE_COUNT * PIPE_DEPTH;
   localparam int ADDR_W = $clog2(MEM_DEPTH);

   // captured request
   mcpft_pkg::action_type action_ff;
   logic [7:0] slot_ff;
   logic       wend_ff;
   logic [7:0] data_ff;
   logic [6:0] len_ff;

   // slot table
   logic              used_ff [PIPE_COUNT];
   logic [CNT_W-1:0]  rcnt_ff [PIPE_COUNT];
   logic [CNT_W-1:0]  wcnt_ff [PIPE_COUNT];
   logic [PTR_W-1:0]  rptr_ff [PIPE_COUNT];
   logic [PTR_W-1:0]  wptr_ff [PIPE_COUNT];
   logic [FILL_W-1:0] fill_ff [PIPE_COUNT];
   logic [TOT_W-1:0]  total_ff;

   // run state
   logic [ADDR_W-1:0] base_ff;
   logic [PTR_W-1:0]  run_ptr_ff;
   logic [RUN_W-1:0]  rem_ff;

   // response registers
   mcpft_pkg::status_type status_ff;
   logic [3:0]  created_ff;
   logic [7:0]  rdata_ff;
   logic        last_ff;
   logic [7:0]  readers_ff;
   logic [7:0]  writers_ff;
   logic [12:0] held_ff;
   logic [4:0]  inuse_ff;

   // lookup results
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic [SLOT_W-1:0] a_idx;
   logic              a_ok;
   logic              good;
   logic              c_used;
   logic [CNT_W-1:0]  c_r, c_w, sel_cnt;
   logic [PTR_W-1:0]  c_rp, c_wp;
   logic [FILL_W-1:0] c_f;
   logic              n_used;
   logic [CNT_W-1:0]  n_r, n_w;
   logic [PTR_W-1:0]  n_rp, n_wp;
   logic [FILL_W-1:0] n_f;
   logic [TOT_W-1:0]  n_total;
   mcpft_pkg::status_type n_status;
   logic              wr_en;
   logic [LEN_W-1:0]  len_c, k_wide;
   logic [FILL_W-1:0] k;
   logic [FILL_W:0]   rp_sum;
   logic [PTR_W:0]    wp_sum, run_sum;
   logic [ADDR_W-1:0] a_base;
   logic [7:0]        ram_q;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= mcpft_pkg::action_type'(req_action);
         slot_ff   <= req_slot;
         wend_ff   <= req_write_end;
         data_ff   <= req_data_byte;
         len_ff    <= req_read_length;
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // addressed slot and its current entry
   always_comb begin
      if (action_ff == mcpft_pkg::ACT_CREATE) begin
         a_idx = free_idx;
         a_ok  = free_found;
      end else begin
         a_idx = SLOT_W'(slot_ff);
         a_ok  = ({1'b0, slot_ff} < 9'(PIPE_COUNT));
      end
      if (a_ok) begin
         c_used = used_ff[a_idx];
         c_r    = rcnt_ff[a_idx];
         c_w    = wcnt_ff[a_idx];
         c_rp   = rptr_ff[a_idx];
         c_wp   = wptr_ff[a_idx];
         c_f    = fill_ff[a_idx];
      end else begin
         c_used = 1'b0;
         c_r    = '0;
         c_w    = '0;
         c_rp   = '0;
         c_wp   = '0;
         c_f    = '0;
      end
   end

   assign good    = a_ok && c_used;
   assign sel_cnt = wend_ff ? c_w : c_r;
   assign a_base  = ADDR_W'(a_idx) * ADDR_W'(PIPE_DEPTH);

   // run length: clamp then limit to the bytes held
   assign len_c  = (len_ff > 7'(MAX_RUN)) ? LEN_W'(MAX_RUN) : LEN_W'(len_ff);
   assign k_wide = (LEN_W'(c_f) < len_c) ? LEN_W'(c_f) : len_c;
   assign k      = FILL_W'(k_wide);
   assign rp_sum = (FILL_W + 1)'(c_rp) + (FILL_W + 1)'(k);
   assign wp_sum = (PTR_W + 1)'(c_wp) + (PTR_W + 1)'(1);

   // table update for the captured request
   always_comb begin
      n_used   = c_used;
      n_r      = c_r;
      n_w      = c_w;
      n_rp     = c_rp;
      n_wp     = c_wp;
      n_f      = c_f;
      n_total  = total_ff;
      n_status = mcpft_pkg::ST_OK;
      wr_en    = 1'b0;
      if (action_ff == mcpft_pkg::ACT_CREATE) begin
         if (free_found) begin
            n_used  = 1'b1;
            n_r     = CNT_W'(1);
            n_w     = CNT_W'(1);
            n_rp    = '0;
            n_wp    = '0;
            n_f     = '0;
            n_total = total_ff + TOT_W'(1);
         end else begin
            n_status = mcpft_pkg::ST_NO_FREE;
         end
      end else if (!good || action_ff > mcpft_pkg::ACT_WRITE) begin
         n_status = mcpft_pkg::ST_BAD_SLOT;
      end else begin
         unique case (action_ff)
            mcpft_pkg::ACT_ABANDON: begin
               n_used  = 1'b0;
               n_total = total_ff - TOT_W'(1);
            end
            mcpft_pkg::ACT_ADD: begin
               if (sel_cnt >= CNT_W'(END_COUNT_MAX)) begin
                  n_status = mcpft_pkg::ST_OVERFLOW;
               end else if (wend_ff) begin
                  n_w = c_w + CNT_W'(1);
               end else begin
                  n_r = c_r + CNT_W'(1);
               end
            end
            mcpft_pkg::ACT_RELEASE: begin
               if (sel_cnt == '0) begin
                  n_status = mcpft_pkg::ST_UNDERFLOW;
               end else if (wend_ff) begin
                  n_w = c_w - CNT_W'(1);
               end else begin
                  n_r = c_r - CNT_W'(1);
               end
               if (n_r == '0 && n_w == '0) begin
                  n_used  = 1'b0;
                  n_total = total_ff - TOT_W'(1);
               end
            end
            mcpft_pkg::ACT_READ: begin
               if (k == '0) begin
                  n_status = (c_w == '0) ? mcpft_pkg::ST_EOF : mcpft_pkg::ST_EMPTY;
               end else begin
                  n_f  = c_f - k;
                  n_rp = (rp_sum >= (FILL_W + 1)'(PIPE_DEPTH)) ?
                         PTR_W'(rp_sum - (FILL_W + 1)'(PIPE_DEPTH)) : PTR_W'(rp_sum);
               end
            end
            mcpft_pkg::ACT_WRITE: begin
               if (c_r == '0) begin
                  n_status = mcpft_pkg::ST_NO_READER;
               end else if (c_f >= FILL_W'(PIPE_DEPTH)) begin
                  n_status = mcpft_pkg::ST_FULL;
               end else begin
                  wr_en = 1'b1;
                  n_f   = c_f + FILL_W'(1);
                  n_wp  = (wp_sum >= (PTR_W + 1)'(PIPE_DEPTH)) ? '0 : PTR_W'(wp_sum);
               end
            end
            default: n_status = mcpft_pkg::ST_BAD_SLOT;
         endcase
         // a freed slot is cleared
         if (!n_used) begin
            n_r  = '0;
            n_w  = '0;
            n_rp = '0;
            n_wp = '0;
            n_f  = '0;
         end
      end
   end

   // slot table registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_COUNT; i++) begin
            used_ff[i] <= 1'b0;
            rcnt_ff[i] <= '0;
            wcnt_ff[i] <= '0;
            rptr_ff[i] <= '0;
            wptr_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (cmd.commit) begin
         if (a_ok) begin
            used_ff[a_idx] <= n_used;
            rcnt_ff[a_idx] <= n_r;
            wcnt_ff[a_idx] <= n_w;
            rptr_ff[a_idx] <= n_rp;
            wptr_ff[a_idx] <= n_wp;
            fill_ff[a_idx] <= n_f;
         end
         total_ff <= n_total;
      end
   end

   // run control
   assign run_sum = (PTR_W + 1)'(run_ptr_ff) + (PTR_W + 1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (cmd.commit) begin
         rem_ff <= (n_status == mcpft_pkg::ST_OK && action_ff == mcpft_pkg::ACT_READ) ?
                   RUN_W'(k) : '0;
      end else if (cmd.rd_capture) begin
         rem_ff <= rem_ff - RUN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         base_ff    <= a_base;
         run_ptr_ff <= c_rp;
      end else if (cmd.rd_issue) begin
         run_ptr_ff <= (run_sum >= (PTR_W + 1)'(PIPE_DEPTH)) ? '0 : PTR_W'(run_sum);
      end
   end

   assign stat.run_start = (n_status == mcpft_pkg::ST_OK) &&
                           (action_ff == mcpft_pkg::ACT_READ) && (k != '0);
   assign stat.run_more  = (rem_ff != '0);

   // byte store
   mcpft_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_en),
      .wr_addr (a_base + ADDR_W'(c_wp)),
      .wr_data (data_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (base_ff + ADDR_W'(run_ptr_ff)),
      .rd_data (ram_q)
   );

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff  <= n_status;
         created_ff <= (action_ff == mcpft_pkg::ACT_CREATE && free_found) ?
                       4'(free_idx) : 4'd0;
         rdata_ff   <= 8'd0;
         last_ff    <= 1'b1;
         readers_ff <= (a_ok && n_used) ? 8'(n_r) : 8'd0;
         writers_ff <= (a_ok && n_used) ? 8'(n_w) : 8'd0;
         held_ff    <= (a_ok && n_used) ? 13'(n_f) : 13'd0;
         inuse_ff   <= 5'(n_total);
      end else if (cmd.rd_capture) begin
         rdata_ff <= ram_q;
         last_ff  <= (rem_ff == RUN_W'(1));
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_created_slot = created_ff;
   assign rsp_read_data    = rdata_ff;
   assign rsp_last_result  = last_ff;
   assign rsp_readers_now  = readers_ff;
   assign rsp_writers_now  = writers_ff;
   assign rsp_bytes_held   = held_ff;
   assign rsp_pipes_in_use = inuse_ff;
endmodule

@@ rtl/core/multi_channel_pipe_fifo_table_core.sv @@
// Top level of the pipe table core: controller plus datapath.
// Uses mcpft_pkg, mcpft_req_if, mcpft_rsp_if, mcpft_ctrl and mcpft_dp.
//
// Usage: a table of byte pipes, each a ring FIFO with reader and writer end
// counts. Each request on req_ch (create, abandon, add_end, release_end,
// read, write) gives one response on rsp_ch, except a read that takes bytes:
// it gives one response per byte, in FIFO order, last_result marking the end.
// Sequence: a non-read response is valid once the lookup state has committed
// the request; a read run's first byte also waits on store read and capture.
// Flow: one request is worked on at a time; a non-read request passes the
// lookup and response states plus any output stall. Each byte of a read run
// passes store read, data capture and response; the store read is registered.
// The next request is taken only after the last response of the current one
// has been taken. While rsp_ch.ready is low the response register holds and
// no new request is taken.
// Reset (synchronous, active high) frees every slot and clears all counts,
// pointers and fills at once; the byte store itself is not cleared.
module multi_channel_pipe_fifo_table_core #(
   parameter int PIPE_COUNT    = mcpft_pkg::PipeCountDef,
   parameter int PIPE_DEPTH    = mcpft_pkg::PipeDepthDef,
   parameter int END_COUNT_MAX = mcpft_pkg::EndCountMaxDef,
   parameter int MAX_RUN       = mcpft_pkg::MaxRunDef
) (
   input logic         clock,
   input logic         reset,
   mcpft_req_if.sink   req_ch,
   mcpft_rsp_if.source rsp_ch
);
   mcpft_pkg::cmd_type  cmd;
   mcpft_pkg::stat_type stat;

   mcpft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   mcpft_dp #(
      .PIPE_COUNT    (PIPE_COUNT),
      .PIPE_DEPTH    (PIPE_DEPTH),
      .END_COUNT_MAX (END_COUNT_MAX),
      .MAX_RUN       (MAX_RUN)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_ch.action),
      .req_slot         (req_ch.slot),
      .req_write_end    (req_ch.write_end),
      .req_data_byte    (req_ch.data_byte),
      .req_read_length  (req_ch.read_length),
      .rsp_status       (rsp_ch.status),
      .rsp_created_slot (rsp_ch.created_slot),
      .rsp_read_data    (rsp_ch.read_data),
      .rsp_last_result  (rsp_ch.last_result),
      .rsp_readers_now  (rsp_ch.readers_now),
      .rsp_writers_now  (rsp_ch.writers_now),
      .rsp_bytes_held   (rsp_ch.bytes_held),
      .rsp_pipes_in_use (rsp_ch.pipes_in_use)
   );
endmodule
